FILE: sv/crc32c_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package crc32c_pkg;

    localparam int ZERO_COUNT_BITS = 32;
    localparam int CRC_W = 32;
    localparam int BYTE_W = 8;
    localparam int COUNT_W = 32;
    localparam int ZC_BITS = (ZERO_COUNT_BITS < COUNT_W) ? ZERO_COUNT_BITS : COUNT_W;
    localparam int K_W = (ZC_BITS > 1) ? $clog2(ZC_BITS) : 1;

    localparam int DIGIT_W = 8;
    localparam int MUL_STEPS = CRC_W / DIGIT_W;
    localparam int STEP_W = (MUL_STEPS > 1) ? $clog2(MUL_STEPS) : 1;

    localparam logic [CRC_W-1:0] POLY_REFL = 32'h82F6_3B78;
    localparam logic [CRC_W-1:0] X8_REFL = 32'h0080_0000;

    localparam logic [1:0] ACT_SEED = 2'd0;
    localparam logic [1:0] ACT_BYTE = 2'd1;
    localparam logic [1:0] ACT_ZERO_RUN = 2'd2;

    typedef logic [CRC_W-1:0] t_crc;
    typedef logic [ZC_BITS-1:0][CRC_W-1:0] t_pow_table;

    typedef struct packed {
        logic load_item;
        logic start_run;
        logic skip_bit;
        logic mul_start;
        logic mul_step;
        logic mul_last;
        logic emit;
    } t_dp_cmd;

    typedef struct packed {
        logic cnt_zero;
        logic cnt_lsb;
    } t_dp_sts;

    function automatic t_crc times_x(input t_crc v);
        return v[0] ? ((v >> 1) ^ POLY_REFL) : (v >> 1);
    endfunction

    function automatic t_crc mul_mod(input t_crc a, input t_crc b);
        t_crc res;
        t_crc bb;
        res = '0;
        bb = b;
        for (int i = 0; i < CRC_W; i++) begin
            if (a[CRC_W-1-i]) begin
                res = res ^ bb;
            end
            bb = times_x(bb);
        end
        return res;
    endfunction

    function automatic t_crc fold_byte(input t_crc crc, input logic [BYTE_W-1:0] data);
        t_crc v;
        v = crc ^ t_crc'(data);
        for (int i = 0; i < BYTE_W; i++) begin
            v = times_x(v);
        end
        return v;
    endfunction

    // x^(8*2^k) mod P for each count bit
    function automatic t_pow_table pow_table();
        t_pow_table t;
        t_crc p;
        p = X8_REFL;
        for (int k = 0; k < ZC_BITS; k++) begin
            t[k] = p;
            p = mul_mod(p, p);
        end
        return t;
    endfunction

    localparam t_pow_table POW_TABLE = pow_table();

endpackage

`default_nettype wire

FILE: sv/crc32c_dp.sv
`timescale 1ns / 1ps
`default_nettype none

module crc32c_dp (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  wire  crc32c_pkg::t_dp_cmd           i_cmd,
    input  wire  [1:0]                          i_action,
    input  wire  [crc32c_pkg::CRC_W-1:0]        i_seed_value,
    input  wire  [crc32c_pkg::BYTE_W-1:0]       i_data_byte,
    input  wire  [crc32c_pkg::COUNT_W-1:0]      i_zero_count,
    output crc32c_pkg::t_dp_sts                 o_sts,
    output logic [crc32c_pkg::CRC_W-1:0]        o_crc_value
);

    crc32c_pkg::t_crc r_crc;
    crc32c_pkg::t_crc r_out;
    crc32c_pkg::t_crc r_a;
    crc32c_pkg::t_crc r_b;
    crc32c_pkg::t_crc r_res;
    crc32c_pkg::t_crc n_b;
    crc32c_pkg::t_crc n_res;
    crc32c_pkg::t_crc item_crc;
    logic [crc32c_pkg::ZC_BITS-1:0] r_cnt;
    logic [crc32c_pkg::K_W-1:0]     r_k;

    always_comb begin
        case (i_action)
            crc32c_pkg::ACT_SEED: item_crc = i_seed_value;
            crc32c_pkg::ACT_BYTE: item_crc = crc32c_pkg::fold_byte(r_crc, i_data_byte);
            default:              item_crc = r_crc;
        endcase
    end

    // one digit of the GF(2) product per cycle
    always_comb begin
        crc32c_pkg::t_crc v_res;
        crc32c_pkg::t_crc v_b;
        v_res = r_res;
        v_b = r_b;
        for (int i = 0; i < crc32c_pkg::DIGIT_W; i++) begin
            if (r_a[crc32c_pkg::CRC_W-1-i]) begin
                v_res = v_res ^ v_b;
            end
            v_b = crc32c_pkg::times_x(v_b);
        end
        n_res = v_res;
        n_b = v_b;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc <= '0;
        end else if (i_cmd.load_item) begin
            r_crc <= item_crc;
        end else if (i_cmd.mul_last) begin
            r_crc <= n_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start_run) begin
            r_cnt <= i_zero_count[crc32c_pkg::ZC_BITS-1:0];
            r_k <= '0;
        end else if (i_cmd.skip_bit || i_cmd.mul_last) begin
            r_cnt <= r_cnt >> 1;
            r_k <= r_k + 1'b1;
        end
        if (i_cmd.mul_start) begin
            r_a <= r_crc;
            r_b <= crc32c_pkg::POW_TABLE[r_k];
            r_res <= '0;
        end else if (i_cmd.mul_step) begin
            r_a <= r_a << crc32c_pkg::DIGIT_W;
            r_b <= n_b;
            r_res <= n_res;
        end
        if (i_cmd.load_item) begin
            r_out <= item_crc;
        end else if (i_cmd.emit) begin
            r_out <= r_crc;
        end
    end

    assign o_sts.cnt_zero = (r_cnt == '0);
    assign o_sts.cnt_lsb = r_cnt[0];
    assign o_crc_value = r_out;

endmodule

`default_nettype wire

FILE: sv/crc32c_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module crc32c_ctrl (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_valid,
    output logic                 o_stall,
    input  wire  [1:0]           i_action,
    output logic                 o_valid,
    input  wire                  i_stall,
    input  wire  crc32c_pkg::t_dp_sts i_sts,
    output crc32c_pkg::t_dp_cmd  o_cmd
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_MUL = 2'd2;
    localparam logic [crc32c_pkg::STEP_W-1:0] STEP_LAST =
        crc32c_pkg::STEP_W'(crc32c_pkg::MUL_STEPS - 1);

    logic [1:0]                    r_state;
    logic [1:0]                    n_state;
    logic [crc32c_pkg::STEP_W-1:0] r_step;
    logic [crc32c_pkg::STEP_W-1:0] n_step;
    logic                          r_out_valid;
    logic                          n_out_valid;
    logic                          out_free;
    logic                          out_load;

    assign out_free = !r_out_valid || !i_stall;

    always_comb begin
        n_state = r_state;
        n_step = r_step;
        out_load = 1'b0;
        o_cmd = '0;
        case (r_state)
            S_IDLE: begin
                if (i_valid && out_free) begin
                    if (i_action == crc32c_pkg::ACT_ZERO_RUN) begin
                        o_cmd.start_run = 1'b1;
                        n_state = S_SCAN;
                    end else begin
                        o_cmd.load_item = 1'b1;
                        out_load = 1'b1;
                    end
                end
            end
            S_SCAN: begin
                if (i_sts.cnt_zero) begin
                    if (out_free) begin
                        o_cmd.emit = 1'b1;
                        out_load = 1'b1;
                        n_state = S_IDLE;
                    end
                end else if (i_sts.cnt_lsb) begin
                    o_cmd.mul_start = 1'b1;
                    n_step = '0;
                    n_state = S_MUL;
                end else begin
                    o_cmd.skip_bit = 1'b1;
                end
            end
            S_MUL: begin
                o_cmd.mul_step = 1'b1;
                if (r_step == STEP_LAST) begin
                    o_cmd.mul_last = 1'b1;
                    n_step = '0;
                    n_state = S_SCAN;
                end else begin
                    n_step = r_step + 1'b1;
                end
            end
            default: begin
                n_state = S_IDLE;
                n_step = '0;
            end
        endcase
    end

    assign n_out_valid = out_load || (r_out_valid && i_stall);
    assign o_stall = !((r_state == S_IDLE) && out_free);
    assign o_valid = r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_step <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_step <= n_step;
            r_out_valid <= n_out_valid;
        end
    end

`ifndef SYNTHESIS
    a_busy_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> o_stall)
        else $error("input taken while a zero run is in progress");

    a_step_in_mul: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_step != '0) |-> (r_state == S_MUL))
        else $error("multiply step count set outside multiply");

    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load |-> out_free)
        else $error("result loaded over a pending transfer");

    a_mul_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_MUL) && (r_step == STEP_LAST)) |=> (r_state == S_SCAN))
        else $error("multiply did not return to scan");
`endif

endmodule

`default_nettype wire

FILE: sv/crc32c_byte_and_zero_run.sv
// Running reflected CRC-32C (poly 0x82F63B78), no initial or final XOR.
// Input channel: i_valid / o_stall with i_action, i_seed_value, i_data_byte,
// i_zero_count. Action 0 loads the seed, 1 folds one data byte, 2 advances
// the CRC over i_zero_count zero bytes, 3 leaves the CRC unchanged.
// Output channel: o_valid / i_stall with o_crc_value, one transfer per item.
// Seed loads and byte folds register their result at the accepting edge, and
// a new item can follow every cycle while the receiver does not stall.
// A zero run loads the count, then walks its bits from the bottom up to the
// highest set bit: a clear bit is skipped, and a set bit runs a 32x32 GF(2)
// multiply by a constant power x^(8*2^k) mod P, one 8-bit digit per cycle;
// then the result is posted.
// Input is stalled for the whole run.
// When the receiver stalls, the result holds in the output register and the
// block stalls its input until that transfer completes.
// Synchronous active-low reset clears the CRC to zero, empties the output
// register and returns the controller to idle.
`timescale 1ns / 1ps
`default_nettype none

module crc32c_byte_and_zero_run (
    input  wire                             i_clk,
    input  wire                             i_rst_n,
    input  wire                             i_valid,
    output logic                            o_stall,
    input  wire  [1:0]                      i_action,
    input  wire  [crc32c_pkg::CRC_W-1:0]    i_seed_value,
    input  wire  [crc32c_pkg::BYTE_W-1:0]   i_data_byte,
    input  wire  [crc32c_pkg::COUNT_W-1:0]  i_zero_count,
    output logic                            o_valid,
    input  wire                             i_stall,
    output logic [crc32c_pkg::CRC_W-1:0]    o_crc_value
);

    crc32c_pkg::t_dp_cmd cmd;
    crc32c_pkg::t_dp_sts sts;

    crc32c_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_stall  (o_stall),
        .i_action (i_action),
        .o_valid  (o_valid),
        .i_stall  (i_stall),
        .i_sts    (sts),
        .o_cmd    (cmd)
    );

    crc32c_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .i_action     (i_action),
        .i_seed_value (i_seed_value),
        .i_data_byte  (i_data_byte),
        .i_zero_count (i_zero_count),
        .o_sts        (sts),
        .o_crc_value  (o_crc_value)
    );

endmodule

`default_nettype wire

FILE: bench/crc32c_byte_and_zero_run_test.sv
`timescale 1ns / 1ps

module crc32c_byte_and_zero_run_test;

    import crc32c_pkg::*;

    localparam logic [1:0] ACT_HOLD = 2'd3;
    localparam int TIMEOUT_NS = 1_200_000;
    localparam int RANDOM_ITEMS = 500;
    localparam int DRAIN_CYCLES = 200;
    localparam int DIR_ROWS = 22;

    typedef struct {
        logic [1:0]         action;
        t_crc               seed;
        logic [BYTE_W-1:0]  data;
        logic [COUNT_W-1:0] count;
        bit                 known;
        t_crc               result;
    } t_crc_cmd;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_valid;
    logic               o_stall;
    logic [1:0]         i_action;
    t_crc               i_seed_value;
    logic [BYTE_W-1:0]  i_data_byte;
    logic [COUNT_W-1:0] i_zero_count;
    logic               o_valid;
    logic               i_stall;
    t_crc               o_crc_value;

    t_crc crc_expected[$];
    t_crc crc_state;
    t_crc crc_want;
    int   err_count = 0;
    int   results_seen = 0;
    int   n_seed = 0;
    int   n_byte = 0;
    int   n_run = 0;
    int   n_hold = 0;
    int   stall_hold = 0;
    int   rx_cycles = 0;
    bit   rx_quiet = 1'b0;
    bit   tx_quiet = 1'b0;

    crc32c_byte_and_zero_run dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_action     (i_action),
        .i_seed_value (i_seed_value),
        .i_data_byte  (i_data_byte),
        .i_zero_count (i_zero_count),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_crc_value  (o_crc_value)
    );

    // Known results only where they follow directly: reset state, seed loads,
    // zero CRC staying zero, empty zero run, unused action.
    t_crc_cmd dir_tab [DIR_ROWS] = '{
        '{ACT_HOLD,     32'hDEAD_BEEF, 8'hFF, 32'hFFFF_FFFF, 1'b1, 32'h0000_0000},
        '{ACT_BYTE,     32'hFFFF_FFFF, 8'h00, 32'hFFFF_FFFF, 1'b1, 32'h0000_0000},
        '{ACT_ZERO_RUN, 32'hFFFF_FFFF, 8'hFF, 32'hFFFF_FFFF, 1'b1, 32'h0000_0000},
        '{ACT_SEED,     32'hFFFF_FFFF, 8'hFF, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF},
        '{ACT_ZERO_RUN, 32'h0000_0000, 8'hFF, 32'h0000_0000, 1'b1, 32'hFFFF_FFFF},
        '{ACT_HOLD,     32'h0000_0000, 8'h00, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF},
        '{ACT_BYTE,     32'h0000_0000, 8'hFF, 32'hFFFF_FFFF, 1'b0, 32'h0000_0000},
        '{ACT_BYTE,     32'hFFFF_FFFF, 8'h00, 32'h0000_0000, 1'b0, 32'h0000_0000},
        '{ACT_BYTE,     32'h0000_0000, 8'h80, 32'h0000_0000, 1'b0, 32'h0000_0000},
        '{ACT_ZERO_RUN, 32'hFFFF_FFFF, 8'hFF, 32'h0000_0001, 1'b0, 32'h0000_0000},
        '{ACT_ZERO_RUN, 32'h0000_0000, 8'h00, 32'hFFFF_FFFF, 1'b0, 32'h0000_0000},
        '{ACT_ZERO_RUN, 32'h0000_0000, 8'h00, 32'h8000_0000, 1'b0, 32'h0000_0000},
        '{ACT_SEED,     32'h0000_0000, 8'hFF, 32'hFFFF_FFFF, 1'b1, 32'h0000_0000},
        '{ACT_SEED,     32'hA5A5_A5A5, 8'h00, 32'h0000_0000, 1'b1, 32'hA5A5_A5A5},
        '{ACT_ZERO_RUN, 32'h0000_0000, 8'h00, 32'hAAAA_AAAA, 1'b0, 32'h0000_0000},
        '{ACT_ZERO_RUN, 32'hFFFF_FFFF, 8'hFF, 32'h5555_5555, 1'b0, 32'h0000_0000},
        '{ACT_BYTE,     32'h0000_0000, 8'h5A, 32'h0000_0000, 1'b0, 32'h0000_0000},
        '{ACT_SEED,     32'h1234_5678, 8'hFF, 32'hFFFF_FFFF, 1'b1, 32'h1234_5678},
        '{ACT_HOLD,     32'h0000_0000, 8'h00, 32'hFFFF_FFFF, 1'b1, 32'h1234_5678},
        '{ACT_ZERO_RUN, 32'h0000_0000, 8'h00, 32'h0000_0004, 1'b0, 32'h0000_0000},
        '{ACT_BYTE,     32'hFFFF_FFFF, 8'h01, 32'hFFFF_FFFF, 1'b0, 32'h0000_0000},
        '{ACT_ZERO_RUN, 32'h0000_0000, 8'h00, 32'h0000_0002, 1'b0, 32'h0000_0000}
    };

    function automatic t_crc crc_shift_x(input t_crc v);
        return v[0] ? ((v >> 1) ^ POLY_REFL) : (v >> 1);
    endfunction

    // bit 31 of each operand is the x^0 term
    function automatic t_crc gf_mul(input t_crc a, input t_crc b);
        t_crc acc;
        acc = '0;
        for (int i = 0; i < CRC_W; i++) begin
            if (a[CRC_W-1-i]) begin
                acc = acc ^ b;
            end
            b = crc_shift_x(b);
        end
        return acc;
    endfunction

    function automatic t_crc crc_add_byte(input t_crc cur, input logic [BYTE_W-1:0] d);
        t_crc v;
        v = cur ^ t_crc'(d);
        for (int i = 0; i < BYTE_W; i++) begin
            v = crc_shift_x(v);
        end
        return v;
    endfunction

    function automatic t_crc crc_skip_zeros(input t_crc cur, input logic [COUNT_W-1:0] n);
        t_crc pw;
        t_crc acc;
        pw = X8_REFL;
        acc = cur;
        for (int k = 0; k < ZERO_COUNT_BITS && k < COUNT_W; k++) begin
            if (n[k]) begin
                acc = gf_mul(acc, pw);
            end
            pw = gf_mul(pw, pw);
        end
        return acc;
    endfunction

    function automatic t_crc crc_apply(input t_crc cur, input t_crc_cmd c);
        case (c.action)
            ACT_SEED: return c.seed;
            ACT_BYTE: return crc_add_byte(cur, c.data);
            ACT_ZERO_RUN: return crc_skip_zeros(cur, c.count);
            default: return cur;
        endcase
    endfunction

    function automatic t_crc_cmd random_cmd();
        t_crc_cmd c;
        int pick;
        int shape;
        pick = $urandom_range(99);
        shape = $urandom_range(9);
        c.seed = ($urandom_range(9) == 0) ? 32'hFFFF_FFFF : $urandom;
        c.data = BYTE_W'($urandom);
        c.known = 1'b0;
        c.result = '0;
        if (shape < 6) begin
            c.count = $urandom_range(16);
        end else if (shape < 8) begin
            c.count = 32'd1 << $urandom_range(COUNT_W - 1);
        end else begin
            c.count = $urandom;
        end
        if (pick < 12) begin
            c.action = ACT_SEED;
        end else if (pick < 62) begin
            c.action = ACT_BYTE;
        end else if (pick < 92) begin
            c.action = ACT_ZERO_RUN;
        end else begin
            c.action = ACT_HOLD;
        end
        return c;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(99);
        if (tx_quiet || r < 60) begin
            return 0;
        end else if (r < 92) begin
            return $urandom_range(3, 1);
        end
        return $urandom_range(40, 8);
    endfunction

    task automatic send_cmd(input t_crc_cmd c, input int gap);
        repeat (gap) begin
            @(negedge i_clk);
            i_valid <= 1'b0;
        end
        @(negedge i_clk);
        i_valid <= 1'b1;
        i_action <= c.action;
        i_seed_value <= c.seed;
        i_data_byte <= c.data;
        i_zero_count <= c.count;
        do @(posedge i_clk); while (o_stall);
        crc_state = crc_apply(crc_state, c);
        crc_expected.push_back(c.known ? c.result : crc_state);
        case (c.action)
            ACT_SEED: n_seed++;
            ACT_BYTE: n_byte++;
            ACT_ZERO_RUN: n_run++;
            default: n_hold++;
        endcase
    endtask

    // drop valid, then hold until every transfer has come back
    task automatic drain();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (crc_expected.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("%0t: timeout with %0d results outstanding", $realtime, crc_expected.size());
        $display("Verification failed");
        $finish;
    end

    always @(negedge i_clk) begin
        rx_cycles++;
        if (rx_cycles % 300 == 0) begin
            rx_quiet = ~rx_quiet;
        end
        if (stall_hold > 0) begin
            stall_hold--;
        end else if (rx_quiet || $urandom_range(99) >= 25) begin
            i_stall <= 1'b0;
        end else begin
            i_stall <= 1'b1;
            stall_hold = ($urandom_range(99) < 90) ? $urandom_range(2) : $urandom_range(60, 10);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            results_seen++;
            if (crc_expected.size() == 0) begin
                err_count++;
                $display("%0t: unexpected result, expected none, actual %h",
                         $realtime, o_crc_value);
            end else begin
                crc_want = crc_expected.pop_front();
                if (o_crc_value !== crc_want) begin
                    err_count++;
                    $display("%0t: crc_value mismatch, expected %h, actual %h",
                             $realtime, crc_want, o_crc_value);
                end
            end
        end
    end

    initial begin
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_stall = 1'b0;
        i_action = ACT_HOLD;
        i_seed_value = '0;
        i_data_byte = '0;
        i_zero_count = '0;
        crc_state = '0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (int i = 0; i < DIR_ROWS; i++) begin
            send_cmd(dir_tab[i], pick_gap());
        end
        drain();

        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            if (i % 40 == 0) begin
                tx_quiet = ~tx_quiet;
            end
            if (i == RANDOM_ITEMS / 2) begin
                drain();
            end
            send_cmd(random_cmd(), pick_gap());
        end
        drain();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Sent %0d transfers: %0d seed loads, %0d byte folds, %0d zero runs, %0d no-ops",
                 n_seed + n_byte + n_run + n_hold, n_seed, n_byte, n_run, n_hold);
        $display("Checked %0d results under random gaps and stalls, %0d errors",
                 results_seen, err_count);
        if (err_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

FILE: sim.f
sv/crc32c_pkg.sv
sv/crc32c_dp.sv
sv/crc32c_ctrl.sv
sv/crc32c_byte_and_zero_run.sv
bench/crc32c_byte_and_zero_run_test.sv
